FILE: hw/rtl/ufmsc_pkg.sv
`default_nettype none
package ufmsc_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int NODE_CNT  = 2048;
    localparam int NODE_W    = $clog2(NODE_CNT);
    localparam int EDGE_AW   = $clog2(MAX_ITEMS);
    localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int IN_NODE_W = 12;
    localparam int COST_W    = 32;
    localparam int SUM_W     = 42;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [NODE_W-1:0] end_a;
        logic [NODE_W-1:0] end_b;
    } t_edge;

    localparam int EDGE_W = $bits(t_edge);

endpackage
`default_nettype wire

FILE: hw/rtl/ufmsc_ram.sv
`default_nettype none
module ufmsc_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [(1 << ADDR_W)];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/union_find_min_spanning_cost.sv
`default_nettype none
// Channel   | Direction | Signals                                   | Handshake
// ----------+-----------+-------------------------------------------+---------------------------
// command   | in        | i_cost, i_node_a1/b1/a2/b2, i_last        | start & !busy
// result    | out       | o_total_cost                              | o_valid, one-cycle strobe
//
// Each transaction runs two unions of two finds each (each find follows the parent hops) and
// two union steps, then a store step plus a read and compare per stored entry while the
// edge slides into cost order (no store once the table is full).
// The last transaction then walks all stored edges, with two finds and a union per edge.
// After reset and after each result, a clearing pass rewrites the parent memory.
// The receiver cannot stall: the result is shown for one cycle while busy stays high.
module union_find_min_spanning_cost (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [ufmsc_pkg::COST_W-1:0]    i_cost,
    input  wire logic [ufmsc_pkg::IN_NODE_W-1:0] i_node_a1,
    input  wire logic [ufmsc_pkg::IN_NODE_W-1:0] i_node_b1,
    input  wire logic [ufmsc_pkg::IN_NODE_W-1:0] i_node_a2,
    input  wire logic [ufmsc_pkg::IN_NODE_W-1:0] i_node_b2,
    input  wire logic                            i_last,
    output logic                                 o_valid,
    output logic [ufmsc_pkg::SUM_W-1:0]          o_total_cost
);

    localparam int NW = ufmsc_pkg::NODE_W;
    localparam int CW = ufmsc_pkg::COUNT_W;
    localparam int AW = ufmsc_pkg::EDGE_AW;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_FA    = 10'b0000000100,
        S_FW    = 10'b0000001000,
        S_UN    = 10'b0000010000,
        S_IR    = 10'b0000100000,
        S_IW    = 10'b0001000000,
        S_IP    = 10'b0010000000,
        S_KR    = 10'b0100000000,
        S_KW    = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        JOB_LOAD1,
        JOB_LOAD2,
        JOB_KRUSKAL
    } t_job;

    t_state r_state, n_state;
    t_job   r_job, n_job;
    logic [NW-1:0] r_clr, n_clr;
    logic [NW-1:0] r_v, n_v;
    logic [NW-1:0] r_y, n_y;
    logic [NW-1:0] r_ra, n_ra;
    logic [NW-1:0] r_a1, n_a1;
    logic [NW-1:0] r_a2, n_a2;
    logic [NW-1:0] r_b2, n_b2;
    logic          r_side, n_side;
    logic          r_last, n_last;
    logic [ufmsc_pkg::COST_W-1:0] r_cost, n_cost;
    logic [ufmsc_pkg::COST_W-1:0] r_ecost, n_ecost;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_i, n_i;
    logic [ufmsc_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [ufmsc_pkg::SUM_W-1:0] r_total, n_total;
    logic          r_valid, n_valid;

    logic          p_we;
    logic [NW-1:0] p_waddr, p_wdata, p_raddr, p_q;
    logic          e_we;
    logic [AW-1:0] e_waddr, e_raddr;
    ufmsc_pkg::t_edge e_wdata, e_q;
    logic [CW-1:0] j_dec;

    ufmsc_ram #(.WIDTH(NW), .ADDR_W(NW)) u_parent (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_q)
    );

    ufmsc_ram #(.WIDTH(ufmsc_pkg::EDGE_W), .ADDR_W(AW)) u_edges (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_q)
    );

    assign busy         = (r_state != S_IDLE) | ~i_rst_n;
    assign o_valid      = r_valid;
    assign o_total_cost = r_total;
    assign j_dec        = r_j - CW'(1);

    // follow the chain straight from the read data while walking
    assign p_raddr = (r_state == S_FW) ? p_q : r_v;
    assign e_raddr = (r_state == S_IR) ? j_dec[AW-1:0] : r_i[AW-1:0];

    // memory write ports
    always_comb begin
        p_we    = 1'b0;
        p_waddr = r_ra;
        p_wdata = r_v;
        e_we    = 1'b0;
        e_waddr = r_j[AW-1:0];
        e_wdata = '{cost: r_cost, end_a: r_a1, end_b: r_a2};
        case (r_state)
            S_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = r_clr;
                p_wdata = r_clr;
            end
            S_UN: begin
                p_we = (r_ra != r_v);
            end
            S_IW: begin
                if (e_q.cost > r_cost) begin
                    e_we    = 1'b1;
                    e_wdata = e_q;
                end
            end
            S_IP: begin
                e_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_clr   = r_clr;
        n_v     = r_v;
        n_y     = r_y;
        n_ra    = r_ra;
        n_a1    = r_a1;
        n_a2    = r_a2;
        n_b2    = r_b2;
        n_side  = r_side;
        n_last  = r_last;
        n_cost  = r_cost;
        n_ecost = r_ecost;
        n_cnt   = r_cnt;
        n_j     = r_j;
        n_i     = r_i;
        n_sum   = r_sum;
        n_total = r_total;
        n_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + NW'(1);
                if (r_clr == {NW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cost  = i_cost;
                    n_a1    = i_node_a1[NW-1:0] - NW'(1);
                    n_a2    = i_node_a2[NW-1:0] - NW'(1);
                    n_b2    = i_node_b2[NW-1:0] - NW'(1);
                    n_last  = i_last;
                    n_v     = i_node_a1[NW-1:0] - NW'(1);
                    n_y     = i_node_b1[NW-1:0] - NW'(1);
                    n_side  = 1'b0;
                    n_job   = JOB_LOAD1;
                    n_state = S_FA;
                end
            end
            S_FA: begin
                n_state = S_FW;
            end
            S_FW: begin
                if (p_q == r_v) begin
                    if (!r_side) begin
                        n_ra    = r_v;
                        n_v     = r_y;
                        n_side  = 1'b1;
                        n_state = S_FA;
                    end else begin
                        n_state = S_UN;
                    end
                end else begin
                    n_v = p_q;
                end
            end
            S_UN: begin
                n_side = 1'b0;
                case (r_job)
                    JOB_LOAD1: begin
                        n_v     = r_a2;
                        n_y     = r_b2;
                        n_job   = JOB_LOAD2;
                        n_state = S_FA;
                    end
                    JOB_LOAD2: begin
                        if (r_cnt < CW'(ufmsc_pkg::MAX_ITEMS)) begin
                            n_j     = r_cnt;
                            n_state = (r_cnt == '0) ? S_IP : S_IR;
                        end else begin
                            n_i     = '0;
                            n_state = r_last ? S_KR : S_IDLE;
                        end
                    end
                    JOB_KRUSKAL: begin
                        if (r_ra != r_v) begin
                            n_sum = r_sum + ufmsc_pkg::SUM_W'(r_ecost);
                        end
                        n_i     = r_i + CW'(1);
                        n_state = S_KR;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_IR: begin
                n_state = S_IW;
            end
            S_IW: begin
                if (e_q.cost > r_cost) begin
                    n_j     = j_dec;
                    n_state = (j_dec == '0) ? S_IP : S_IR;
                end else begin
                    n_state = S_IP;
                end
            end
            S_IP: begin
                n_cnt   = r_cnt + CW'(1);
                n_i     = '0;
                n_state = r_last ? S_KR : S_IDLE;
            end
            S_KR: begin
                if (r_i == r_cnt) begin
                    n_valid = 1'b1;
                    n_total = r_sum;
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_clr   = '0;
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_KW;
                end
            end
            S_KW: begin
                n_v     = e_q.end_a;
                n_y     = e_q.end_b;
                n_ecost = e_q.cost;
                n_side  = 1'b0;
                n_job   = JOB_KRUSKAL;
                n_state = S_FA;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
            r_job   <= JOB_LOAD1;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_valid <= n_valid;
            r_job   <= n_job;
            r_side  <= n_side;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_y     <= n_y;
        r_ra    <= n_ra;
        r_a1    <= n_a1;
        r_a2    <= n_a2;
        r_b2    <= n_b2;
        r_last  <= n_last;
        r_cost  <= n_cost;
        r_ecost <= n_ecost;
        r_j     <= n_j;
        r_i     <= n_i;
        r_total <= n_total;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ufmsc_checker.sv
`default_nettype none
module ufmsc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_last,
    input wire logic o_valid
);

    // reset starts the clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    // a result is shown while the block is busy
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result outside busy");

    // a result is followed by the clearing pass
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && busy))
        else $error("result repeated or block idle after result");

    // an accepted transaction keeps the block busy and gives no result at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accept did not raise busy");

    // a transaction that is not the last gives no result while its first find walks the chain
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> ##1 !o_valid)
        else $error("result without last");

endmodule

bind union_find_min_spanning_cost ufmsc_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_last  (i_last),
    .o_valid (o_valid)
);
`default_nettype wire
